### src/assert_macros.svh
// Assertion macros used by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only outside reset.
`define DBAD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Checked at every rising edge, reset included.
`define DBAD_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

### src/dbad_pkg.sv
// Types, codes and helpers for the disk block allocator directory.
`timescale 1ns / 1ps
package dbad_pkg;

  parameter int DBAD_ENTRIES          = 16;
  parameter int DBAD_TOTAL_BLOCKS     = 96;
  parameter int DBAD_BLOCKS_PER_ENTRY = 16;

  localparam int NAME_BYTES = 8;
  localparam int TYPE_BYTES = 3;

  // command kinds
  localparam logic [2:0] K_CLEAR = 3'd0;
  localparam logic [2:0] K_OPEN  = 3'd1;
  localparam logic [2:0] K_ALLOC = 3'd2;
  localparam logic [2:0] K_DEL   = 3'd3;
  localparam logic [2:0] K_LIST  = 3'd4;

  // result status codes
  localparam logic [2:0] STS_DONE     = 3'd0;
  localparam logic [2:0] STS_OPENED   = 3'd1;
  localparam logic [2:0] STS_CREATED  = 3'd2;
  localparam logic [2:0] STS_BAD_NAME = 3'd3;
  localparam logic [2:0] STS_DIR_FULL = 3'd4;
  localparam logic [2:0] STS_NOT_OPEN = 3'd5;
  localparam logic [2:0] STS_FILE_FUL = 3'd6;
  localparam logic [2:0] STS_DISK_FUL = 3'd7;

  typedef struct packed {
    logic [63:0] name;
    logic [23:0] ftype;
    logic [4:0]  count;
  } dir_t;

  // keep bytes up to the first zero byte
  function automatic logic [63:0] trim_name(input logic [63:0] v);
    logic [63:0] r;
    logic        stop;
    r    = '0;
    stop = 1'b0;
    for (int i = 0; i < NAME_BYTES; i++) begin
      if (v[8*i +: 8] == 8'd0) stop = 1'b1;
      if (!stop) r[8*i +: 8] = v[8*i +: 8];
    end
    return r;
  endfunction

  function automatic logic [23:0] trim_type(input logic [23:0] v);
    logic [23:0] r;
    logic        stop;
    r    = '0;
    stop = 1'b0;
    for (int i = 0; i < TYPE_BYTES; i++) begin
      if (v[8*i +: 8] == 8'd0) stop = 1'b1;
      if (!stop) r[8*i +: 8] = v[8*i +: 8];
    end
    return r;
  endfunction

endpackage

### src/disk_block_allocator_directory.sv
// Top level: file directory and first-fit bitmap block allocator.
`timescale 1ns / 1ps
//
// Channel   Signals                                            Handshake
// command   kind_i file_name_i file_type_i entry_i             start & !busy
// result    status_o entry_index_o block_number_o last_o       valid_o, one cycle
//
// Work per command: clear disk writes CLR_N addresses (CLR_N =
// max(TOTAL_BLOCKS, ENTRIES*BLOCKS_PER_ENTRY), 256 by default); open/create
// reads up to ENTRIES directory entries; allocate reads the free map from
// block 1 up; delete and list walk BLOCKS_PER_ENTRY slots; rejects and unknown
// kinds answer without a walk. Each walk step is a registered read, then a check.
// Reset starts a clearing pass of CLR_N addresses over all three memories,
// with busy high; it gives no result. Results cannot be stalled; list gives
// BLOCKS_PER_ENTRY results, last set on the final one.
//
// State: directory memory (name, type, count per entry), block-list memory
// (ENTRIES*BLOCKS_PER_ENTRY slots) and free-map memory (one bit per block).
// One command runs at a time, so every write lands before the next read.
module disk_block_allocator_directory #(
  parameter int ENTRIES          = dbad_pkg::DBAD_ENTRIES,
  parameter int TOTAL_BLOCKS     = dbad_pkg::DBAD_TOTAL_BLOCKS,
  parameter int BLOCKS_PER_ENTRY = dbad_pkg::DBAD_BLOCKS_PER_ENTRY
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  logic [2:0]        kind_i,
  input  logic [63:0]       file_name_i,
  input  logic [23:0]       file_type_i,
  input  logic signed [4:0] entry_i,
  output logic              valid_o,
  output logic [2:0]        status_o,
  output logic [3:0]        entry_index_o,
  output logic [6:0]        block_number_o,
  output logic              last_o
);
  import dbad_pkg::*;
  `include "assert_macros.svh"

  localparam int SLOTS = ENTRIES * BLOCKS_PER_ENTRY;
  localparam int CLR_N = (SLOTS > TOTAL_BLOCKS) ? SLOTS : TOTAL_BLOCKS;
  localparam int CW    = $clog2(CLR_N + 1);
  localparam int EW    = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int SW    = (BLOCKS_PER_ENTRY > 1) ? $clog2(BLOCKS_PER_ENTRY) : 1;
  localparam int BAW   = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int FAW   = $clog2(TOTAL_BLOCKS);

  localparam logic [3:0] S_CLR     = 4'd0;
  localparam logic [3:0] S_IDLE    = 4'd1;
  localparam logic [3:0] S_DIR_RD  = 4'd2;
  localparam logic [3:0] S_DIR_CK  = 4'd3;
  localparam logic [3:0] S_ENT_CK  = 4'd4;
  localparam logic [3:0] S_FREE_RD = 4'd5;
  localparam logic [3:0] S_FREE_CK = 4'd6;
  localparam logic [3:0] S_DEL_RD  = 4'd7;
  localparam logic [3:0] S_DEL_CK  = 4'd8;
  localparam logic [3:0] S_LST_RD  = 4'd9;
  localparam logic [3:0] S_LST_CK  = 4'd10;

  // memories
  dir_t       dir_mem  [ENTRIES];
  logic [6:0] blk_mem  [SLOTS];
  logic       free_mem [TOTAL_BLOCKS];

  dir_t             dir_rd_q, dir_wd;
  logic [6:0]       blk_rd_q, blk_wd;
  logic             free_rd_q, free_wd;
  logic             dir_we, blk_we, free_we;
  logic [EW-1:0]    dir_ra, dir_wa;
  logic [BAW-1:0]   blk_ra, blk_wa;
  logic [FAW-1:0]   free_ra, free_wa;

  // control
  logic [3:0]       state_q, state_d;
  logic [CW-1:0]    cnt_q, cnt_d;
  logic             clr_emit_q, clr_emit_d;
  logic             have_q, have_d;
  logic [EW-1:0]    empty_q, empty_d;

  // per-command data
  logic [2:0]       kind_q, kind_d;
  logic [63:0]      name_q, name_d;
  logic [23:0]      type_q, type_d;
  logic [EW-1:0]    e_q, e_d;
  dir_t             ent_q, ent_d;

  // result register
  logic             valid_q;
  logic [2:0]       status_q;
  logic [3:0]       idx_q;
  logic [6:0]       blkn_q;
  logic             last_q;
  logic             emit_c, last_c;
  logic [2:0]       sts_c;
  logic [3:0]       idx_c;
  logic [6:0]       blkn_c;

  logic [4:0]       eraw;
  logic             ent_ok;
  logic [63:0]      name_trim;
  logic [BAW-1:0]   slot_addr;

  assign eraw      = entry_i;
  assign ent_ok    = !eraw[4] && (eraw < 5'(ENTRIES));
  assign name_trim = trim_name(file_name_i);
  assign busy      = (state_q != S_IDLE);

  // slot address of the open entry: the counter walks slots, except on append
  assign slot_addr = BAW'(e_q) * BAW'(BLOCKS_PER_ENTRY) +
                     ((state_q == S_FREE_CK) ? BAW'(ent_q.count[SW-1:0])
                                             : BAW'(cnt_q[SW-1:0]));

  always_comb begin
    dir_ra  = (state_q == S_IDLE) ? eraw[EW-1:0] : cnt_q[EW-1:0];
    blk_ra  = slot_addr;
    free_ra = cnt_q[FAW-1:0];
  end

  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q;
    clr_emit_d = clr_emit_q;
    have_d     = have_q;
    empty_d    = empty_q;
    kind_d     = kind_q;
    name_d     = name_q;
    type_d     = type_q;
    e_d        = e_q;
    ent_d      = ent_q;
    dir_we     = 1'b0;
    dir_wa     = e_q;
    dir_wd     = '0;
    blk_we     = 1'b0;
    blk_wa     = slot_addr;
    blk_wd     = '0;
    free_we    = 1'b0;
    free_wa    = cnt_q[FAW-1:0];
    free_wd    = 1'b0;
    emit_c     = 1'b0;
    sts_c      = STS_DONE;
    idx_c      = '0;
    blkn_c     = '0;
    last_c     = 1'b1;

    unique case (state_q)
      S_CLR: begin
        // one entry of each memory per cycle
        dir_we  = cnt_q < CW'(ENTRIES);
        dir_wa  = cnt_q[EW-1:0];
        blk_we  = cnt_q < CW'(SLOTS);
        blk_wa  = cnt_q[BAW-1:0];
        free_we = cnt_q < CW'(TOTAL_BLOCKS);
        if (cnt_q == CW'(CLR_N - 1)) begin
          emit_c  = clr_emit_q;
          state_d = S_IDLE;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      S_IDLE: begin
        if (start) begin
          kind_d = kind_i;
          name_d = name_trim;
          type_d = trim_type(file_type_i);
          e_d    = eraw[EW-1:0];
          cnt_d  = '0;
          unique case (kind_i)
            K_CLEAR: begin
              clr_emit_d = 1'b1;
              state_d    = S_CLR;
            end
            K_OPEN: begin
              if (name_trim == '0) begin
                emit_c = 1'b1;
                sts_c  = STS_BAD_NAME;
              end else begin
                have_d  = 1'b0;
                state_d = S_DIR_RD;
              end
            end
            K_ALLOC, K_DEL, K_LIST: begin
              if (!ent_ok) begin
                emit_c = 1'b1;
                sts_c  = STS_NOT_OPEN;
              end else begin
                state_d = S_ENT_CK;
              end
            end
            default: emit_c = 1'b1;
          endcase
        end
      end
      S_DIR_RD: state_d = S_DIR_CK;
      S_DIR_CK: begin
        if (dir_rd_q.name == name_q && dir_rd_q.ftype == type_q) begin
          emit_c  = 1'b1;
          sts_c   = STS_OPENED;
          idx_c   = 4'(cnt_q[EW-1:0]);
          state_d = S_IDLE;
        end else begin
          if (dir_rd_q.name == '0 && !have_q) begin
            have_d  = 1'b1;
            empty_d = cnt_q[EW-1:0];
          end
          if (cnt_q == CW'(ENTRIES - 1)) begin
            emit_c  = 1'b1;
            state_d = S_IDLE;
            if (have_d) begin
              dir_we       = 1'b1;
              dir_wa       = empty_d;
              dir_wd.name  = name_q;
              dir_wd.ftype = type_q;
              sts_c        = STS_CREATED;
              idx_c        = 4'(empty_d);
            end else begin
              sts_c = STS_DIR_FULL;
            end
          end else begin
            cnt_d   = cnt_q + 1'b1;
            state_d = S_DIR_RD;
          end
        end
      end
      S_ENT_CK: begin
        ent_d = dir_rd_q;
        if (dir_rd_q.name == '0) begin
          emit_c  = 1'b1;
          sts_c   = STS_NOT_OPEN;
          state_d = S_IDLE;
        end else begin
          priority case (kind_q)
            K_ALLOC: begin
              if (dir_rd_q.count >= 5'(BLOCKS_PER_ENTRY)) begin
                emit_c  = 1'b1;
                sts_c   = STS_FILE_FUL;
                idx_c   = 4'(e_q);
                state_d = S_IDLE;
              end else begin
                cnt_d   = CW'(1);
                state_d = S_FREE_RD;
              end
            end
            K_DEL:   state_d = S_DEL_RD;
            default: state_d = S_LST_RD;
          endcase
        end
      end
      S_FREE_RD: state_d = S_FREE_CK;
      S_FREE_CK: begin
        if (!free_rd_q) begin
          free_we      = 1'b1;
          free_wd      = 1'b1;
          blk_we       = 1'b1;
          blk_wd       = 7'(cnt_q);
          dir_we       = 1'b1;
          dir_wd       = ent_q;
          dir_wd.count = ent_q.count + 5'd1;
          emit_c       = 1'b1;
          idx_c        = 4'(e_q);
          blkn_c       = 7'(cnt_q);
          state_d      = S_IDLE;
        end else if (cnt_q == CW'(TOTAL_BLOCKS - 1)) begin
          emit_c  = 1'b1;
          sts_c   = STS_DISK_FUL;
          idx_c   = 4'(e_q);
          state_d = S_IDLE;
        end else begin
          cnt_d   = cnt_q + 1'b1;
          state_d = S_FREE_RD;
        end
      end
      S_DEL_RD: state_d = S_DEL_CK;
      S_DEL_CK: begin
        // free counted blocks, zero every slot
        free_wa = blk_rd_q[FAW-1:0];
        free_we = (5'(cnt_q) < ent_q.count) && (blk_rd_q < 7'(TOTAL_BLOCKS));
        blk_we  = 1'b1;
        if (cnt_q == CW'(BLOCKS_PER_ENTRY - 1)) begin
          dir_we  = 1'b1;
          emit_c  = 1'b1;
          idx_c   = 4'(e_q);
          state_d = S_IDLE;
        end else begin
          cnt_d   = cnt_q + 1'b1;
          state_d = S_DEL_RD;
        end
      end
      S_LST_RD: state_d = S_LST_CK;
      S_LST_CK: begin
        emit_c = 1'b1;
        idx_c  = 4'(e_q);
        blkn_c = blk_rd_q;
        if (cnt_q == CW'(BLOCKS_PER_ENTRY - 1)) begin
          state_d = S_IDLE;
        end else begin
          last_c  = 1'b0;
          cnt_d   = cnt_q + 1'b1;
          state_d = S_LST_RD;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // memory ports
  always_ff @(posedge clk_i) begin
    if (dir_we) dir_mem[dir_wa] <= dir_wd;
    dir_rd_q <= dir_mem[dir_ra];
  end

  always_ff @(posedge clk_i) begin
    if (blk_we) blk_mem[blk_wa] <= blk_wd;
    blk_rd_q <= blk_mem[blk_ra];
  end

  always_ff @(posedge clk_i) begin
    if (free_we) free_mem[free_wa] <= free_wd;
    free_rd_q <= free_mem[free_ra];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_CLR;
      cnt_q      <= '0;
      clr_emit_q <= 1'b0;
      have_q     <= 1'b0;
      valid_q    <= 1'b0;
    end else begin
      state_q    <= state_d;
      cnt_q      <= cnt_d;
      clr_emit_q <= clr_emit_d;
      have_q     <= have_d;
      valid_q    <= emit_c;
    end
  end

  always_ff @(posedge clk_i) begin
    kind_q   <= kind_d;
    name_q   <= name_d;
    type_q   <= type_d;
    e_q      <= e_d;
    ent_q    <= ent_d;
    empty_q  <= empty_d;
    status_q <= sts_c;
    idx_q    <= idx_c;
    blkn_q   <= blkn_c;
    last_q   <= last_c;
  end

  assign valid_o        = valid_q;
  assign status_o       = status_q;
  assign entry_index_o  = idx_q;
  assign block_number_o = blkn_q;
  assign last_o         = last_q;

  `DBAD_ASSERT(a_last_idle, ((valid_o && last_o) |-> (state_q == S_IDLE)), "last result while busy")
  `DBAD_ASSERT(a_mid_list, ((valid_o && !last_o) |-> (state_q == S_LST_RD)), "stray partial result")
  `DBAD_ASSERT(a_caused, (valid_o |-> ($past(busy) || $past(start))), "result without command")
  `DBAD_ASSERT_ALWAYS(a_clr_quiet, ((state_q == S_CLR) |-> !valid_o), "result during clear pass")

endmodule

### tb/sv/disk_block_allocator_directory_checker.sv
// Checker: predicts directory and allocator results and compares them.
`timescale 1ns / 1ps
module disk_block_allocator_directory_checker
  import dbad_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic              busy_i,
  input  logic [2:0]        kind_i,
  input  logic [63:0]       file_name_i,
  input  logic [23:0]       file_type_i,
  input  logic signed [4:0] entry_i,
  input  logic              valid_i,
  input  logic [2:0]        status_i,
  input  logic [3:0]        entry_index_i,
  input  logic [6:0]        block_number_i,
  input  logic              last_i,
  output int                pending_o,
  output int                errors_o
);

  localparam int NE = DBAD_ENTRIES;
  localparam int NB = DBAD_TOTAL_BLOCKS;
  localparam int BPE = DBAD_BLOCKS_PER_ENTRY;

  typedef struct packed {
    logic [2:0] status;
    logic [3:0] idx;
    logic [6:0] blk;
    logic       last;
  } answer_t;

  logic        used_map [NB];
  logic [63:0] dir_name [NE];
  logic [23:0] dir_type [NE];
  int          dir_count[NE];
  logic [6:0]  dir_blocks[NE][BPE];

  answer_t answers_due[$];
  int      errors;
  int      pending;

  assign pending_o = pending;
  assign errors_o  = errors;

  function automatic logic [63:0] cut_at_nul(input logic [63:0] v, input int nbytes);
    logic [63:0] r;
    r = '0;
    for (int i = 0; i < nbytes; i++) begin
      if (v[8*i +: 8] == 8'd0) break;
      r[8*i +: 8] = v[8*i +: 8];
    end
    return r;
  endfunction

  task automatic wipe_disk();
    for (int b = 0; b < NB; b++) used_map[b] = 1'b0;
    for (int e = 0; e < NE; e++) begin
      dir_name[e]  = '0;
      dir_type[e]  = '0;
      dir_count[e] = 0;
      for (int s = 0; s < BPE; s++) dir_blocks[e][s] = '0;
    end
  endtask

  task automatic queue_answer(input logic [2:0] st, input int idx, input int blk,
                              input logic lst);
    answer_t a;
    a.status = st;
    a.idx    = 4'(idx);
    a.blk    = 7'(blk);
    a.last   = lst;
    answers_due.push_back(a);
  endtask

  task automatic run_command(input logic [2:0] kind, input logic [63:0] nm_raw,
                             input logic [23:0] ty_raw, input logic [4:0] ent);
    logic [63:0] nm;
    logic [23:0] ty;
    int          e;
    bit          done;
    nm   = cut_at_nul(nm_raw, 8);
    ty   = 24'(cut_at_nul({40'd0, ty_raw}, 3));
    e    = int'(ent);
    done = 0;
    case (kind)
      K_CLEAR: begin
        wipe_disk();
        queue_answer(STS_DONE, 0, 0, 1'b1);
      end
      K_OPEN: begin
        if (nm == '0) begin
          queue_answer(STS_BAD_NAME, 0, 0, 1'b1);
          done = 1;
        end
        for (int i = 0; i < NE && !done; i++)
          if (dir_name[i] == nm && dir_type[i] == ty) begin
            queue_answer(STS_OPENED, i, 0, 1'b1);
            done = 1;
          end
        for (int i = 0; i < NE && !done; i++)
          if (dir_name[i] == '0) begin
            dir_name[i] = nm;
            dir_type[i] = ty;
            queue_answer(STS_CREATED, i, 0, 1'b1);
            done = 1;
          end
        if (!done) queue_answer(STS_DIR_FULL, 0, 0, 1'b1);
      end
      K_ALLOC, K_DEL, K_LIST: begin
        // negative entries have bit 4 set; empty names are not open either
        if (ent[4] || e >= NE || dir_name[e] == '0) begin
          queue_answer(STS_NOT_OPEN, 0, 0, 1'b1);
        end else if (kind == K_ALLOC) begin
          if (dir_count[e] >= BPE) begin
            queue_answer(STS_FILE_FUL, e, 0, 1'b1);
            done = 1;
          end
          for (int b = 1; b < NB && !done; b++)
            if (!used_map[b]) begin
              used_map[b] = 1'b1;
              dir_blocks[e][dir_count[e]] = 7'(b);
              dir_count[e]++;
              queue_answer(STS_DONE, e, b, 1'b1);
              done = 1;
            end
          if (!done) queue_answer(STS_DISK_FUL, e, 0, 1'b1);
        end else if (kind == K_DEL) begin
          for (int s = 0; s < dir_count[e]; s++) used_map[dir_blocks[e][s]] = 1'b0;
          for (int s = 0; s < BPE; s++) dir_blocks[e][s] = '0;
          dir_name[e]  = '0;
          dir_type[e]  = '0;
          dir_count[e] = 0;
          queue_answer(STS_DONE, e, 0, 1'b1);
        end else begin
          for (int s = 0; s < BPE; s++)
            queue_answer(STS_DONE, e, dir_blocks[e][s], s == BPE - 1);
        end
      end
      default: queue_answer(STS_DONE, 0, 0, 1'b1); // unused kinds: no effect
    endcase
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    answer_t want;
    if (!rst_ni) begin
      wipe_disk();
      answers_due.delete();
      errors  = 0;
      pending = 0;
    end else begin
      if (valid_i) begin
        if (answers_due.size() == 0) begin
          $error("unexpected result: status %0d index %0d block %0d last %0b",
                 status_i, entry_index_i, block_number_i, last_i);
          errors++;
        end else begin
          want = answers_due.pop_front();
          if (status_i !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, status_i);
            errors++;
          end
          if (entry_index_i !== want.idx) begin
            $error("entry_index: expected %0d, got %0d", want.idx, entry_index_i);
            errors++;
          end
          if (block_number_i !== want.blk) begin
            $error("block_number: expected %0d, got %0d", want.blk, block_number_i);
            errors++;
          end
          if (last_i !== want.last) begin
            $error("last: expected %0b, got %0b", want.last, last_i);
            errors++;
          end
        end
      end
      // item taken at this edge: predict after consuming this edge's result
      if (start_i && !busy_i) run_command(kind_i, file_name_i, file_type_i, entry_i);
      pending = answers_due.size();
    end
  end

endmodule

### tb/sv/disk_block_allocator_directory_tb.sv
// Testbench top: command stimulus for the directory/allocator and verdict.
`timescale 1ns / 1ps
module disk_block_allocator_directory_tb;
  import dbad_pkg::*;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              start = 1'b0;
  logic [2:0]        kind_i = K_CLEAR;
  logic [63:0]       file_name_i = '0;
  logic [23:0]       file_type_i = '0;
  logic signed [4:0] entry_i = '0;
  logic              busy, valid_o, last_o;
  logic [2:0]        status_o;
  logic [3:0]        entry_index_o;
  logic [6:0]        block_number_o;
  int                pending, errors;
  int                burst_left;

  // 8 ns clock
  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  disk_block_allocator_directory u_dut (
    .clk_i, .rst_ni, .start, .busy, .kind_i, .file_name_i, .file_type_i, .entry_i,
    .valid_o, .status_o, .entry_index_o, .block_number_o, .last_o
  );

  disk_block_allocator_directory_checker u_chk (
    .clk_i, .rst_ni, .start_i(start), .busy_i(busy), .kind_i, .file_name_i,
    .file_type_i, .entry_i, .valid_i(valid_o), .status_i(status_o),
    .entry_index_i(entry_index_o), .block_number_i(block_number_o),
    .last_i(last_o), .pending_o(pending), .errors_o(errors)
  );

  // Drive one item at the current rising edge and return at the edge that takes it.
  // start stays high; a following gap lowers it at that same edge.
  task automatic issue(input logic [2:0] k, input logic [63:0] nm, input logic [23:0] ty,
                       input logic [4:0] ent);
    start       <= 1'b1;
    kind_i      <= k;
    file_name_i <= nm;
    file_type_i <= ty;
    entry_i     <= ent;
    do @(negedge clk_i); while (busy);
    @(posedge clk_i);
    // sender idles in bursts: random run of back-to-back items, then often a gap
    if (burst_left > 0) burst_left--;
    else begin
      burst_left = $urandom_range(0, 6);
      if ($urandom_range(0, 2) != 0) begin
        start <= 1'b0;
        repeat ($urandom_range(1, 40)) @(posedge clk_i);
      end
    end
  endtask

  // hold off until every expected result is in
  task automatic drain();
    start <= 1'b0;
    do @(negedge clk_i); while (pending != 0);
    @(posedge clk_i);
  endtask

  // small name pool so opens hit existing entries; the tail past a NUL is noise
  function automatic logic [63:0] pick_name();
    logic [63:0] nm;
    int          len;
    if ($urandom_range(0, 19) == 0) return {$urandom, $urandom};
    if ($urandom_range(0, 29) == 0) return {$urandom, $urandom} & 64'hFFFF_FFFF_FFFF_FF00;
    len = $urandom_range(1, 8);
    nm  = '0;
    for (int i = 0; i < len; i++) nm[8*i +: 8] = 8'h41 + 8'($urandom_range(0, 1));
    if (len < 7 && $urandom_range(0, 3) == 0)
      nm[8*(len+1) +: 8] = 8'($urandom_range(1, 255));
    return nm;
  endfunction

  function automatic logic [23:0] pick_type();
    case ($urandom_range(0, 5))
      0: return 24'h545854;          // "TXT"
      1: return 24'h4D4F43;          // "COM"
      2: return 24'h000000;
      3: return 24'h7A0042;          // "B", tail ignored
      4: return 24'($urandom);
      default: return 24'h544144;    // "DAT"
    endcase
  endfunction

  function automatic logic [4:0] pick_entry();
    if ($urandom_range(0, 9) == 0) return 5'($urandom_range(16, 31)); // negative
    if ($urandom_range(0, 3) == 0) return 5'($urandom_range(0, 15));
    return 5'($urandom_range(0, 5));
  endfunction

  initial begin
    logic [2:0] k;
    burst_left = 0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: empty name, create, allocate, list, delete, bad entries
    issue(K_OPEN,  64'h0,                  24'h545854, 5'd0);
    issue(K_OPEN,  64'h0000_0000_0000_0041, 24'h545854, 5'd0);
    issue(K_OPEN,  64'h4141_00FF_0000_0041, 24'h005854, 5'd0);
    issue(K_OPEN,  64'hFFFF_FFFF_FFFF_FFFF, 24'hFFFFFF, 5'd0);
    issue(K_ALLOC, 64'h0, 24'h0, 5'd0);
    issue(K_ALLOC, 64'h0, 24'h0, 5'd1);
    issue(K_ALLOC, 64'h0, 24'h0, 5'd2);
    issue(K_ALLOC, 64'h0, 24'h0, 5'd15);
    issue(K_ALLOC, 64'h0, 24'h0, 5'b11111);
    issue(K_ALLOC, 64'h0, 24'h0, 5'b10000);
    issue(K_LIST,  64'h0, 24'h0, 5'd0);
    issue(K_DEL,   64'h0, 24'h0, 5'd0);
    issue(K_ALLOC, 64'h0, 24'h0, 5'd2);
    issue(K_LIST,  64'h0, 24'h0, 5'd2);
    issue(K_DEL,   64'h0, 24'h0, 5'd0);
    issue(K_LIST,  64'h0, 24'h0, 5'd7);
    issue(3'd5,    64'h0, 24'h0, 5'd0);
    issue(3'd6,    64'h0, 24'h0, 5'd0);
    issue(3'd7,    64'hFFFF_FFFF_FFFF_FFFF, 24'hFFFFFF, 5'b11111);
    drain();
    issue(K_CLEAR, 64'h0, 24'h0, 5'd0);
    issue(K_LIST,  64'h0, 24'h0, 5'd0);

    // random: mostly opens and allocates so files fill up, the disk runs out
    // and the directory fills; deletes and clears are rare
    for (int n = 0; n < 330; n++) begin
      case ($urandom_range(0, 99)) inside
        [0:1]:   k = K_CLEAR;
        [2:25]:  k = K_OPEN;
        [26:75]: k = K_ALLOC;
        [76:84]: k = K_DEL;
        [85:95]: k = K_LIST;
        default: k = 3'($urandom_range(5, 7));
      endcase
      issue(k, pick_name(), pick_type(), pick_entry());
      if (n == 160) drain();
    end

    drain();
    repeat (300) @(posedge clk_i);
    if (errors == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    #20ms;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule

### filelist.f
+incdir+src
src/dbad_pkg.sv
src/disk_block_allocator_directory.sv
tb/sv/disk_block_allocator_directory_checker.sv
tb/sv/disk_block_allocator_directory_tb.sv
